### src/axis_angle_vector_rotation_unit_macros.svh
// Assertion macros shared by the checker of the axis-angle rotation unit.
// Depends on nothing; included by the checker file only.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_UNIT_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define AAVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define AAVR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### src/aavr_pkg.sv
// Shared constants, types and helper functions of the axis-angle rotation unit.
// Depends on nothing; used by every module of the block.
`default_nettype none
package aavr_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 31;

  // Pipeline timing, in cycles after the input beat is accepted.
  localparam int T_LEN     = 3 + SQRT_STAGES;
  localparam int T_U       = T_LEN + DIV_STAGES;
  localparam int T_LANE_IN = T_U + 2;
  localparam int T_TRIG    = T_LANE_IN + 2;
  localparam int LATENCY   = T_LANE_IN + 4;
  localparam int ANG_DLY   = T_TRIG - 3 - CORDIC_STEPS;
  localparam int A_DLY     = T_LEN - 1;
  localparam int V_DLY     = LATENCY - 2;
  localparam int Z_DLY     = LATENCY - 4;

  localparam int TRIG_W = 34;
  localparam int D16_W  = 36;

  localparam logic signed [32:0] ANG_2PI     = 33'sd1686629713;
  localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
  localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
  } trig_t;

  // Round half up from Q46 to Q16 (floor of x + 2^29 over 2^30).
  function automatic logic signed [41:0] rnd30(input logic signed [71:0] x);
    logic signed [71:0] s;
    s = (x + 72'sd536870912) >>> 30;
    return s[41:0];
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/aavr_sqrt.sv
// Pipelined floor square root of the squared axis length, one result bit per stage.
// Depends on aavr_pkg.
`default_nettype none
module aavr_sqrt (
  input  wire logic        clk,
  input  wire logic        ce,
  input  wire logic [63:0] sumsq,
  output logic      [31:0] len
);

  logic [65:0] rem_r  [aavr_pkg::SQRT_STAGES];
  logic [31:0] root_r [aavr_pkg::SQRT_STAGES];

  for (genvar j = 0; j < aavr_pkg::SQRT_STAGES; j++) begin : g_st
    localparam int B = aavr_pkg::SQRT_STAGES - 1 - j;
    logic [65:0] rem_in;
    logic [31:0] root_in;
    logic [65:0] trial;
    if (j == 0) begin : g_first
      assign rem_in  = {2'b00, sumsq};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end
    // (root + 2^B)^2 - root^2
    assign trial = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (ce) begin
        if (rem_in >= trial) begin
          rem_r[j]  <= rem_in - trial;
          root_r[j] <= root_in | (32'd1 << B);
        end else begin
          rem_r[j]  <= rem_in;
          root_r[j] <= root_in;
        end
      end
    end
  end

  assign len = root_r[aavr_pkg::SQRT_STAGES-1];

endmodule
`default_nettype wire

### src/aavr_div.sv
// Pipelined restoring divider of one lane: u = trunc(|a| * 2^30 / len) with the sign of a.
// Depends on aavr_pkg.
`default_nettype none
module aavr_div (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [31:0] a,
  input  wire logic        [31:0] len,
  output logic signed      [31:0] u
);

  localparam int N = aavr_pkg::DIV_STAGES;

  logic [62:0] rem_r [N];
  logic [30:0] q_r   [N];
  logic [31:0] len_r [N];
  logic        neg_r [N];
  logic [31:0] mag;
  logic [31:0] q32;

  assign mag = a[31] ? (~a + 32'd1) : a;

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam int B = N - 1 - j;
    logic [62:0] rem_in;
    logic [30:0] q_in;
    logic [31:0] len_in;
    logic        neg_in;
    logic [62:0] dvs;
    if (j == 0) begin : g_first
      assign rem_in = {1'b0, mag, 30'd0};
      assign q_in   = '0;
      assign len_in = len;
      assign neg_in = a[31];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign len_in = len_r[j-1];
      assign neg_in = neg_r[j-1];
    end
    assign dvs = {31'd0, len_in} << B;
    always_ff @(posedge clk) begin
      if (ce) begin
        len_r[j] <= len_in;
        neg_r[j] <= neg_in;
        if (rem_in >= dvs) begin
          rem_r[j] <= rem_in - dvs;
          q_r[j]   <= q_in | (31'd1 << B);
        end else begin
          rem_r[j] <= rem_in;
          q_r[j]   <= q_in;
        end
      end
    end
  end

  assign q32 = {1'b0, q_r[N-1]};
  assign u   = neg_r[N-1] ? (~q32 + 32'd1) : q32;

endmodule
`default_nettype wire

### src/aavr_cordic.sv
// Pipelined CORDIC: range reduction, fold, fixed iterations, then sine and cosine in Q2.30.
// Depends on aavr_pkg.
`default_nettype none
module aavr_cordic (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [31:0] ang,
  output aavr_pkg::trig_t         trig
);

  localparam int W = aavr_pkg::TRIG_W;
  localparam int S = aavr_pkg::CORDIC_STEPS;

  logic signed [32:0]  a0, a1, a2;
  logic                fold;
  logic signed [W-1:0] z0_r;
  logic                neg0_r;
  logic signed [W-1:0] x_r [S];
  logic signed [W-1:0] y_r [S];
  logic signed [W-1:0] z_r [S];
  logic                neg_r [S];
  aavr_pkg::trig_t     trig_r;

  // Reduce by 2*pi, then fold into [-pi/2, pi/2].
  always_comb begin
    a0 = 33'(ang);
    if (a0 > aavr_pkg::ANG_PI) begin
      a1 = a0 - aavr_pkg::ANG_2PI;
    end else if (a0 < -aavr_pkg::ANG_PI) begin
      a1 = a0 + aavr_pkg::ANG_2PI;
    end else begin
      a1 = a0;
    end
    if (a1 > aavr_pkg::ANG_HALF_PI) begin
      a2   = a1 - aavr_pkg::ANG_PI;
      fold = 1'b1;
    end else if (a1 < -aavr_pkg::ANG_HALF_PI) begin
      a2   = a1 + aavr_pkg::ANG_PI;
      fold = 1'b1;
    end else begin
      a2   = a1;
      fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      z0_r   <= W'(a2) <<< 2;
      neg0_r <= fold;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_it
    logic signed [W-1:0] x_in, y_in, z_in, at;
    logic                neg_in;
    if (i == 0) begin : g_first
      assign x_in   = aavr_pkg::CORDIC_GAIN;
      assign y_in   = '0;
      assign z_in   = z0_r;
      assign neg_in = neg0_r;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign neg_in = neg_r[i-1];
    end
    assign at = W'(aavr_pkg::atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (ce) begin
        neg_r[i] <= neg_in;
        if (!z_in[W-1]) begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - at;
        end else begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      trig_r.sn <= neg_r[S-1] ? -y_r[S-1] : y_r[S-1];
      trig_r.cs <= neg_r[S-1] ? -x_r[S-1] : x_r[S-1];
    end
  end

  assign trig = trig_r;

endmodule
`default_nettype wire

### src/aavr_lane.sv
// One output component: v*cos + (u x v)*sin + u*(u.v)*(1 - cos), rounded and clamped.
// Depends on aavr_pkg.
`default_nettype none
module aavr_lane (
  input  wire logic                                 clk,
  input  wire logic                                 ce,
  input  wire logic signed [31:0]                   u,
  input  wire logic signed [31:0]                   v,
  input  wire logic signed [aavr_pkg::D16_W-1:0]    c16,
  input  wire logic signed [aavr_pkg::D16_W-1:0]    d16,
  input  wire aavr_pkg::trig_t                      trig,
  output logic signed [31:0]                        rot,
  output logic                                      sat
);

  localparam int DW = aavr_pkg::D16_W;
  localparam int TW = aavr_pkg::TRIG_W;

  logic signed [DW+31:0]    pud_r;
  logic signed [31:0]       v3_r, v4_r;
  logic signed [DW-1:0]     c3_r, c4_r, t_r;
  logic signed [TW+31:0]    pv_r;
  logic signed [DW+TW-1:0]  pc_r;
  logic signed [DW+TW:0]    pt_r;
  logic signed [TW:0]       omc;
  logic signed [41:0]       sum;

  assign omc = 35'sd1073741824 - (TW+1)'(trig.cs);

  always_ff @(posedge clk) begin
    if (ce) begin
      pud_r <= (DW+32)'(u) * (DW+32)'(d16);
      v3_r  <= v;
      c3_r  <= c16;
      t_r   <= DW'(aavr_pkg::rnd30(72'(pud_r)));
      v4_r  <= v3_r;
      c4_r  <= c3_r;
      pv_r  <= (TW+32)'(v4_r) * (TW+32)'(trig.cs);
      pc_r  <= (DW+TW)'(c4_r) * (DW+TW)'(trig.sn);
      pt_r  <= (DW+TW+1)'(t_r) * (DW+TW+1)'(omc);
    end
  end

  always_comb begin
    sum = aavr_pkg::rnd30(72'(pv_r)) + aavr_pkg::rnd30(72'(pc_r))
        + aavr_pkg::rnd30(72'(pt_r));
    if (sum > 42'sd2147483647) begin
      rot = 32'sh7FFFFFFF;
      sat = 1'b1;
    end else if (sum < -42'sd2147483648) begin
      rot = 32'sh80000000;
      sat = 1'b1;
    end else begin
      rot = sum[31:0];
      sat = 1'b0;
    end
  end

endmodule
`default_nettype wire

### src/axis_angle_vector_rotation_unit.sv
// Axis-angle vector rotation, fixed point, pipelined from input beat to result beat.
// Throughput one beat per cycle; latency is set by the 32-stage square root and the
// 31-stage dividers in series, with the CORDIC running alongside on a delayed angle.
// An output stall freezes the whole pipeline and drops in_tready until the beat is taken.
// Reset (rst_n low, synchronous) clears the valid line; payload registers are not reset.
`default_nettype none
module axis_angle_vector_rotation_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, angle (32 bits each, lowest first)
  input  wire logic [223:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // rot_x, rot_y, rot_z (32 bits each, lowest first)
  output logic [95:0]       out_tdata,
  // zero_axis, saturated (lowest first)
  output logic [1:0]        out_tuser
);

  // Global advance: the pipeline moves whenever the output register is free or drained.
  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  logic vld_r [aavr_pkg::LATENCY];

  // Input capture, squares, squared length.
  logic signed [31:0] a_r [3];
  logic signed [31:0] v_r [3];
  logic signed [31:0] ang_r;
  logic [63:0]        sq_r [3];
  logic [63:0]        sumsq_r;
  logic               zero_c_r;
  logic [63:0]        sumsq_nxt;

  assign sumsq_nxt = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (ce) begin
      a_r[0] <= in_tdata[31:0];
      a_r[1] <= in_tdata[63:32];
      a_r[2] <= in_tdata[95:64];
      v_r[0] <= in_tdata[127:96];
      v_r[1] <= in_tdata[159:128];
      v_r[2] <= in_tdata[191:160];
      ang_r  <= in_tdata[223:192];
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(64'(a_r[i]) * 64'(a_r[i]));
      end
      sumsq_r  <= sumsq_nxt;
      zero_c_r <= (sumsq_nxt == 64'd0);
    end
  end

  // Delay lines that carry operands alongside the long arithmetic units.
  logic signed [31:0] a_sh_r   [aavr_pkg::A_DLY][3];
  logic signed [31:0] v_sh_r   [aavr_pkg::V_DLY][3];
  logic               z_sh_r   [aavr_pkg::Z_DLY];
  logic signed [31:0] ang_sh_r [aavr_pkg::ANG_DLY];

  always_ff @(posedge clk) begin
    if (ce) begin
      a_sh_r[0]   <= a_r;
      v_sh_r[0]   <= v_r;
      z_sh_r[0]   <= zero_c_r;
      ang_sh_r[0] <= ang_r;
      for (int k = 1; k < aavr_pkg::A_DLY; k++) a_sh_r[k] <= a_sh_r[k-1];
      for (int k = 1; k < aavr_pkg::V_DLY; k++) v_sh_r[k] <= v_sh_r[k-1];
      for (int k = 1; k < aavr_pkg::Z_DLY; k++) z_sh_r[k] <= z_sh_r[k-1];
      for (int k = 1; k < aavr_pkg::ANG_DLY; k++) ang_sh_r[k] <= ang_sh_r[k-1];
    end
  end

  // Axis length, then one divider lane per component to normalize the axis.
  logic [31:0]        len;
  logic signed [31:0] u   [3];
  logic signed [31:0] u1_r [3];
  logic signed [31:0] u2_r [3];

  aavr_sqrt u_sqrt (
    .clk   (clk),
    .ce    (ce),
    .sumsq (sumsq_r),
    .len   (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    aavr_div u_div (
      .clk (clk),
      .ce  (ce),
      .a   (a_sh_r[aavr_pkg::A_DLY-1][i]),
      .len (len),
      .u   (u[i])
    );
  end

  // Sine and cosine, timed to land when the lanes need them.
  aavr_pkg::trig_t trig;

  aavr_cordic u_cordic (
    .clk  (clk),
    .ce   (ce),
    .ang  (ang_sh_r[aavr_pkg::ANG_DLY-1]),
    .trig (trig)
  );

  // All nine u_i * v_j products, then cross and dot product rounded to Q16.16.
  logic signed [63:0]                   p_r [3][3];
  logic signed [aavr_pkg::D16_W-1:0]    c16_r [3];
  logic signed [aavr_pkg::D16_W-1:0]    d16_r;
  logic signed [31:0]                   vu [3];

  assign vu = v_sh_r[aavr_pkg::T_U - 2];

  always_ff @(posedge clk) begin
    if (ce) begin
      u1_r <= u;
      u2_r <= u1_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i][j] <= 64'(u[i]) * 64'(vu[j]);
        end
      end
      c16_r[0] <= aavr_pkg::D16_W'(aavr_pkg::rnd30(72'(p_r[1][2]) - 72'(p_r[2][1])));
      c16_r[1] <= aavr_pkg::D16_W'(aavr_pkg::rnd30(72'(p_r[2][0]) - 72'(p_r[0][2])));
      c16_r[2] <= aavr_pkg::D16_W'(aavr_pkg::rnd30(72'(p_r[0][1]) - 72'(p_r[1][0])));
      d16_r    <= aavr_pkg::D16_W'(aavr_pkg::rnd30(72'(p_r[0][0]) + 72'(p_r[1][1])
                                                   + 72'(p_r[2][2])));
    end
  end

  // Per-component lanes.
  logic signed [31:0] rot [3];
  logic               lsat [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    aavr_lane u_lane (
      .clk  (clk),
      .ce   (ce),
      .u    (u2_r[i]),
      .v    (v_sh_r[aavr_pkg::T_LANE_IN - 2][i]),
      .c16  (c16_r[i]),
      .d16  (d16_r),
      .trig (trig),
      .rot  (rot[i]),
      .sat  (lsat[i])
    );
  end

  // Merge: pick the passthrough vector on a zero axis, combine the clamp flags.
  logic signed [31:0] vout [3];
  logic               zero_o;
  logic [95:0]        tdata_r;
  logic [1:0]         tuser_r;

  assign vout   = v_sh_r[aavr_pkg::LATENCY - 3];
  assign zero_o = z_sh_r[aavr_pkg::Z_DLY - 1];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        tdata_r[32*i +: 32] <= zero_o ? vout[i] : rot[i];
      end
      tuser_r <= {!zero_o && (lsat[0] || lsat[1] || lsat[2]), zero_o};
    end
  end

  // Valid line: advance with the pipeline, clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < aavr_pkg::LATENCY; k++) vld_r[k] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < aavr_pkg::LATENCY; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign out_tvalid = vld_r[aavr_pkg::LATENCY-1];
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

endmodule
`default_nettype wire

### src/aavr_chk.sv
// Port-level checker of the axis-angle rotation unit, bound to the top level.
// Depends on axis_angle_vector_rotation_unit_macros.svh.
`default_nettype none
`include "axis_angle_vector_rotation_unit_macros.svh"
module aavr_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [95:0]  out_tdata,
  input wire logic [1:0]   out_tuser
);

  // Hold a stalled result beat.
  `AAVR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // A stalled output freezes intake.
  `AAVR_ASSERT_SAME(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready)
  // A zero axis never reports a clamp.
  `AAVR_ASSERT_SAME(a_zero_no_sat, out_tvalid && out_tuser[0], !out_tuser[1])
  // Intake is open whenever the output register is empty.
  `AAVR_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready)

endmodule

bind axis_angle_vector_rotation_unit aavr_chk u_aavr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
